/* rtl/look_at_yaw_pitch_core_assert.svh */
// Assertion macros for the look-at yaw/pitch core
`ifndef LOOK_AT_YAW_PITCH_CORE_ASSERT_SVH
`define LOOK_AT_YAW_PITCH_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define LYP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("look_at_yaw_pitch_core: check failed");
`define LYP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("look_at_yaw_pitch_core: check failed");
`else
`define LYP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define LYP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/lyp_pkg.sv */
// Shared widths, CORDIC angle table and angle rounding for the look-at core
`timescale 1ns / 1ps
package lyp_pkg;

	localparam int COORD_W    = 32;
	localparam int DIFF_W     = COORD_W + 1;
	localparam int GUARD_BITS = 8;
	localparam int CW         = 46;
	localparam int ACC_W      = 32;
	localparam int ANG_W      = 16;
	localparam int GAIN_W     = 16;

	localparam logic [GAIN_W-1:0] INV_GAIN = 16'd39797;
	localparam logic [ACC_W-1:0]  ACC_HALF = 32'h8000_0000;
	localparam logic [ACC_W-1:0]  ACC_RND  = 32'h0000_8000;

	localparam logic [ACC_W-1:0] ATAN_TAB [32] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

	function automatic logic [ANG_W-1:0] to_bam(input logic [ACC_W-1:0] acc);
		logic [ACC_W-1:0] sum;
		sum = acc + ACC_RND;
		return sum[ACC_W-1:ACC_W-ANG_W];
	endfunction

endpackage

/* rtl/lyp_cordic.sv */
// Pipelined CORDIC vectoring unit with half-plane pre-rotation and sideband
`timescale 1ns / 1ps
module lyp_cordic #(
	parameter int ITER   = 16,
	parameter int SIDE_W = 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic signed [lyp_pkg::CW-1:0]     x_in,
	input  logic signed [lyp_pkg::CW-1:0]     y_in,
	input  logic        [SIDE_W-1:0]          side_in,
	output logic                              out_valid,
	output logic signed [lyp_pkg::CW-1:0]     mag,
	output logic        [lyp_pkg::ACC_W-1:0]  acc,
	output logic        [SIDE_W-1:0]          side_out
);

	logic signed [lyp_pkg::CW-1:0]    x_s    [ITER+1];
	logic signed [lyp_pkg::CW-1:0]    y_s    [ITER+1];
	logic        [lyp_pkg::ACC_W-1:0] acc_s  [ITER+1];
	logic        [SIDE_W-1:0]         side_s [ITER+1];
	logic        [ITER:0]             vld_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[ITER-1:0], in_valid};
		end
	end

	// rotate the left half plane by pi
	always_ff @(posedge clk) begin
		if (x_in[lyp_pkg::CW-1]) begin
			x_s[0]   <= -x_in;
			y_s[0]   <= -y_in;
			acc_s[0] <= lyp_pkg::ACC_HALF;
		end else begin
			x_s[0]   <= x_in;
			y_s[0]   <= y_in;
			acc_s[0] <= '0;
		end
		side_s[0] <= side_in;
	end

	for (genvar i = 0; i < ITER; i++) begin : g_stage
		always_ff @(posedge clk) begin
			if (y_s[i][lyp_pkg::CW-1]) begin
				x_s[i+1]   <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1]   <= y_s[i] + (x_s[i] >>> i);
				acc_s[i+1] <= acc_s[i] - lyp_pkg::ATAN_TAB[i];
			end else begin
				x_s[i+1]   <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1]   <= y_s[i] - (x_s[i] >>> i);
				acc_s[i+1] <= acc_s[i] + lyp_pkg::ATAN_TAB[i];
			end
			side_s[i+1] <= side_s[i];
		end
	end

	assign out_valid = vld_s[ITER];
	assign mag       = x_s[ITER];
	assign acc       = acc_s[ITER];
	assign side_out  = side_s[ITER];

endmodule

/* rtl/look_at_yaw_pitch_core.sv */
// Look-at yaw/pitch core: direction, yaw CORDIC, gain scale, pitch CORDIC
//
// channel   dir  handshake          payload
// request   in   start & !busy      target_present, target_x/y/z, camera_x/y/z
// result    out  done (one cycle)   pitch_angle, yaw_angle
//
// One request per cycle; busy is always low.
// Latency is set by the two CORDIC pipelines (ANGLE_ITERATIONS deep).
// A request with target_present low gives no result.
// Reset clears the valid bits only; requests in flight are dropped.
// The receiver cannot stall, so nothing holds the pipeline.
`timescale 1ns / 1ps
`include "look_at_yaw_pitch_core_assert.svh"
module look_at_yaw_pitch_core #(
	parameter int ANGLE_ITERATIONS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               target_present,
	input  logic signed [31:0] target_x,
	input  logic signed [31:0] target_y,
	input  logic signed [31:0] target_z,
	input  logic signed [31:0] camera_x,
	input  logic signed [31:0] camera_y,
	input  logic signed [31:0] camera_z,
	output logic               done,
	output logic signed [15:0] pitch_angle,
	output logic signed [15:0] yaw_angle
);

	localparam int CW     = lyp_pkg::CW;
	localparam int DW     = lyp_pkg::DIFF_W;
	localparam int GB     = lyp_pkg::GUARD_BITS;
	localparam int AW     = lyp_pkg::ANG_W;
	localparam int YSIDE  = DW + 1;
	localparam int PSIDE  = AW + 1;
	localparam int LAT    = 2 * ANGLE_ITERATIONS + 5;
	localparam int ZDLY   = LAT - 2;

	logic                          vld_s1;
	logic signed [DW-1:0]          dx_s1, dy_s1, dz_s1;
	logic signed [CW-1:0]          yaw_x, yaw_y;
	logic                          hz_zero;

	logic                          yaw_vld;
	logic signed [CW-1:0]          yaw_mag;
	logic [lyp_pkg::ACC_W-1:0]     yaw_acc;
	logic [YSIDE-1:0]              yaw_side;
	logic [CW+lyp_pkg::GAIN_W-1:0] prod;

	logic                          vld_s2;
	logic [CW-1:0]                 r_s2;
	logic signed [DW-1:0]          dy_s2;
	logic [AW-1:0]                 yaw_s2;
	logic signed [CW-1:0]          dyg;
	logic                          pz_zero;

	logic                          pit_vld;
	logic signed [CW-1:0]          pit_mag;
	logic [lyp_pkg::ACC_W-1:0]     pit_acc;
	logic [PSIDE-1:0]              pit_side;

	logic                          done_q;
	logic [AW-1:0]                 pitch_q, yaw_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= start && !busy && target_present;
			vld_s2 <= yaw_vld;
			done_q <= pit_vld;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1 <= {target_x[31], target_x} - {camera_x[31], camera_x};
		dy_s1 <= {target_y[31], target_y} - {camera_y[31], camera_y};
		dz_s1 <= {target_z[31], target_z} - {camera_z[31], camera_z};
	end

	assign yaw_x   = {{(CW-DW-GB){dz_s1[DW-1]}}, dz_s1, {GB{1'b0}}};
	assign yaw_y   = {{(CW-DW-GB){dx_s1[DW-1]}}, dx_s1, {GB{1'b0}}};
	assign hz_zero = (dx_s1 == '0) && (dz_s1 == '0);

	lyp_cordic #(
		.ITER   (ANGLE_ITERATIONS),
		.SIDE_W (YSIDE)
	) u_yaw (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s1),
		.x_in      (yaw_x),
		.y_in      (yaw_y),
		.side_in   ({hz_zero, dy_s1}),
		.out_valid (yaw_vld),
		.mag       (yaw_mag),
		.acc       (yaw_acc),
		.side_out  (yaw_side)
	);

	assign prod = {{lyp_pkg::GAIN_W{1'b0}}, $unsigned(yaw_mag)}
		* {{CW{1'b0}}, lyp_pkg::INV_GAIN};

	always_ff @(posedge clk) begin
		r_s2   <= prod[CW+lyp_pkg::GAIN_W-1:lyp_pkg::GAIN_W];
		dy_s2  <= yaw_side[DW-1:0];
		yaw_s2 <= yaw_side[DW] ? '0 : lyp_pkg::to_bam(yaw_acc);
	end

	assign dyg     = {{(CW-DW-GB){dy_s2[DW-1]}}, dy_s2, {GB{1'b0}}};
	assign pz_zero = (r_s2 == '0) && (dy_s2 == '0);

	lyp_cordic #(
		.ITER   (ANGLE_ITERATIONS),
		.SIDE_W (PSIDE)
	) u_pitch (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s2),
		.x_in      ($signed(r_s2)),
		.y_in      (-dyg),
		.side_in   ({pz_zero, yaw_s2}),
		.out_valid (pit_vld),
		.mag       (pit_mag),
		.acc       (pit_acc),
		.side_out  (pit_side)
	);

	always_ff @(posedge clk) begin
		pitch_q <= pit_side[AW] ? '0 : lyp_pkg::to_bam(pit_acc);
		yaw_q   <= pit_side[AW-1:0];
	end

	assign done        = done_q;
	assign pitch_angle = $signed(pitch_q);
	assign yaw_angle   = $signed(yaw_q);

	`LYP_ASSERT_IMPL(a_lat_fwd, clk, arst_n, start && !busy && target_present, ##LAT done)
	`LYP_ASSERT_IMPL(a_lat_back, clk, arst_n, done, $past(start && !busy && target_present, LAT))
	`LYP_ASSERT_NEXT(a_zero_vec, clk, arst_n, vld_s1 && hz_zero && (dy_s1 == '0), ##ZDLY (pitch_angle == '0 && yaw_angle == '0))
	`LYP_ASSERT_NEXT(a_zero_yaw, clk, arst_n, vld_s1 && hz_zero, ##ZDLY (yaw_angle == '0))
	`LYP_ASSERT_IMPL(a_yaw_mag_pos, clk, arst_n, yaw_vld, !yaw_mag[CW-1])
	`LYP_ASSERT_IMPL(a_pit_mag_pos, clk, arst_n, pit_vld, !pit_mag[CW-1])

endmodule

/* sim/look_at_yaw_pitch_core_tb.sv */
// Self-checking testbench for look_at_yaw_pitch_core: directed and random look-at requests
`timescale 1ns / 1ps
module look_at_yaw_pitch_core_tb;

	localparam int ITERS       = 16;
	localparam int LATENCY     = 2 * ITERS + 5;
	localparam int RANDOM_REQS = 1800;
	localparam int CYCLE_LIMIT = 400000;

	typedef logic signed [63:0] wide_t;

	typedef struct {
		logic               present;
		logic signed [31:0] tx, ty, tz;
		logic signed [31:0] cx, cy, cz;
	} look_req_t;

	typedef struct {
		logic signed [lyp_pkg::ANG_W-1:0] pitch;
		logic signed [lyp_pkg::ANG_W-1:0] yaw;
	} look_angles_t;

	logic               clk;
	logic               arst_n         = 1'b0;
	logic               start          = 1'b0;
	logic               busy;
	logic               target_present = 1'b0;
	logic signed [31:0] target_x       = '0;
	logic signed [31:0] target_y       = '0;
	logic signed [31:0] target_z       = '0;
	logic signed [31:0] camera_x       = '0;
	logic signed [31:0] camera_y       = '0;
	logic signed [31:0] camera_z       = '0;
	logic               done;
	logic signed [15:0] pitch_angle;
	logic signed [15:0] yaw_angle;

	look_angles_t expected_angles[$];
	int           mismatches  = 0;
	int           cycle_count = 0;
	int           burst_left  = 0;

	look_at_yaw_pitch_core #(
		.ANGLE_ITERATIONS(ITERS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.target_present(target_present),
		.target_x(target_x),
		.target_y(target_y),
		.target_z(target_z),
		.camera_x(camera_x),
		.camera_y(camera_y),
		.camera_z(camera_z),
		.done(done),
		.pitch_angle(pitch_angle),
		.yaw_angle(yaw_angle)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [lyp_pkg::ACC_W-1:0] cordic_angle(input wide_t x_in,
			input wide_t y_in, output wide_t magnitude);
		wide_t                     x, y, xs, ys;
		logic [lyp_pkg::ACC_W-1:0] acc;
		x   = x_in;
		y   = y_in;
		acc = '0;
		if (x < 0) begin
			x   = -x;
			y   = -y;
			acc = lyp_pkg::ACC_HALF;
		end
		for (int i = 0; i < ITERS && i < 32; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y < 0) begin
				x   = x - ys;
				y   = y + xs;
				acc = acc - lyp_pkg::ATAN_TAB[i];
			end else begin
				x   = x + ys;
				y   = y - xs;
				acc = acc + lyp_pkg::ATAN_TAB[i];
			end
		end
		magnitude = x;
		return acc;
	endfunction

	function automatic logic [lyp_pkg::ANG_W-1:0] round_angle(
			input logic [lyp_pkg::ACC_W-1:0] acc);
		logic [lyp_pkg::ACC_W-1:0] sum;
		sum = acc + 32'h0000_8000;
		return sum[lyp_pkg::ACC_W-1:lyp_pkg::ACC_W-lyp_pkg::ANG_W];
	endfunction

	function automatic look_angles_t predict_look_at(input look_req_t r);
		wide_t                     dx, dy, dz, mag, horiz, unused;
		logic [lyp_pkg::ACC_W-1:0] yaw_acc, pitch_acc;
		look_angles_t              a;
		dx        = (wide_t'(r.tx) - wide_t'(r.cx)) <<< lyp_pkg::GUARD_BITS;
		dy        = (wide_t'(r.ty) - wide_t'(r.cy)) <<< lyp_pkg::GUARD_BITS;
		dz        = (wide_t'(r.tz) - wide_t'(r.cz)) <<< lyp_pkg::GUARD_BITS;
		mag       = '0;
		yaw_acc   = '0;
		pitch_acc = '0;
		if (dx != 0 || dz != 0)
			yaw_acc = cordic_angle(dz, dx, mag);
		horiz = (mag * wide_t'({48'd0, lyp_pkg::INV_GAIN})) >>> 16;
		if (horiz != 0 || dy != 0)
			pitch_acc = cordic_angle(horiz, -dy, unused);
		a.pitch = round_angle(pitch_acc);
		a.yaw   = round_angle(yaw_acc);
		return a;
	endfunction

	function automatic look_req_t make_req(input logic present,
			input logic signed [31:0] tx, ty, tz, cx, cy, cz);
		look_req_t r;
		r.present = present;
		r.tx = tx; r.ty = ty; r.tz = tz;
		r.cx = cx; r.cy = cy; r.cz = cz;
		return r;
	endfunction

	function automatic logic signed [31:0] small_offset();
		logic [31:0] v;
		int          k;
		k = $urandom_range(0, 24);
		v = $urandom & ((32'd1 << k) - 32'd1);
		return $urandom_range(0, 1) ? -$signed(v) : $signed(v);
	endfunction

	function automatic logic signed [31:0] corner_coord();
		case ($urandom_range(0, 5))
			0: return 32'sh8000_0000;
			1: return 32'sh7FFF_FFFF;
			2: return 32'sd0;
			3: return -32'sd1;
			4: return 32'sd1;
			default: return $signed($urandom);
		endcase
	endfunction

	function automatic look_req_t random_req();
		look_req_t r;
		int        mode;
		r.present = ($urandom_range(0, 99) >= 8);
		r.cx = $signed($urandom);
		r.cy = $signed($urandom);
		r.cz = $signed($urandom);
		mode = $urandom_range(0, 9);
		case (mode)
			3, 4, 5: begin
				r.tx = r.cx + small_offset();
				r.ty = r.cy + small_offset();
				r.tz = r.cz + small_offset();
			end
			6: begin
				r.tx = r.cx;
				r.ty = r.cy;
				r.tz = r.cz;
				case ($urandom_range(0, 2))
					0: r.tx = r.cx + small_offset();
					1: r.ty = r.cy + small_offset();
					default: r.tz = r.cz + small_offset();
				endcase
			end
			7: begin
				r.tx = corner_coord(); r.ty = corner_coord(); r.tz = corner_coord();
				r.cx = corner_coord(); r.cy = corner_coord(); r.cz = corner_coord();
			end
			8: begin
				r.tx = r.cx;
				r.tz = r.cz;
				r.ty = r.cy + small_offset();
			end
			default: begin
				r.tx = $signed($urandom);
				r.ty = $signed($urandom);
				r.tz = $signed($urandom);
			end
		endcase
		return r;
	endfunction

	task automatic send_request(input look_req_t r);
		start          <= 1'b1;
		target_present <= r.present;
		target_x       <= r.tx;
		target_y       <= r.ty;
		target_z       <= r.tz;
		camera_x       <= r.cx;
		camera_y       <= r.cy;
		camera_z       <= r.cz;
		do @(posedge clk); while (busy);
		if (r.present)
			expected_angles.push_back(predict_look_at(r));
	endtask

	// unless steady, hold start low for a random gap once the current burst runs out
	task automatic pace(input bit steady);
		int gap;
		if (steady)
			return;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		burst_left = $urandom_range(0, 15);
		gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 20) : $urandom_range(0, 3);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic test_coordinate_extremes();
		look_req_t list[$];
		list.push_back(make_req(1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
			32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
		list.push_back(make_req(1, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
			32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
		list.push_back(make_req(1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
			32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000));
		list.push_back(make_req(1, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
			32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF));
		list.push_back(make_req(1, 32'sd1, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0));
		list.push_back(make_req(1, -32'sd1, -32'sd1, 32'sd1, 32'sd0, 32'sd0, 32'sd0));
		list.push_back(make_req(1, 32'sd0, 32'sd0, 32'sd0, -32'sd1, -32'sd1, -32'sd1));
		list.push_back(make_req(1, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1));
		foreach (list[i])
			send_request(list[i]);
	endtask

	task automatic test_special_cases();
		look_req_t list[$];
		// zero vector
		list.push_back(make_req(1, 32'sd5, -32'sd9, 32'sd77, 32'sd5, -32'sd9, 32'sd77));
		// zero horizontal vector, target above and below
		list.push_back(make_req(1, 32'sd3, 32'sh0001_0000, 32'sd4, 32'sd3, 32'sd0, 32'sd4));
		list.push_back(make_req(1, 32'sd3, -32'sh0001_0000, 32'sd4, 32'sd3, 32'sd0, 32'sd4));
		list.push_back(make_req(1, 32'sd0, 32'sh7FFF_FFFF, 32'sd0, 32'sd0, 32'sh8000_0000, 32'sd0));
		// target behind the camera: negative z operand
		list.push_back(make_req(1, 32'sh0000_8000, 32'sd0, -32'sh0002_0000, 32'sd0, 32'sd0, 32'sd0));
		list.push_back(make_req(1, -32'sh0000_8000, 32'sd7, -32'sh0002_0000, 32'sd0, 32'sd0, 32'sd0));
		// straight behind: half turn
		list.push_back(make_req(1, 32'sd0, 32'sd0, -32'sh0001_0000, 32'sd0, 32'sd0, 32'sd0));
		list.push_back(make_req(1, 32'sd0, 32'sd0, 32'sh8000_0000, 32'sd0, 32'sd0, 32'sh7FFF_FFFF));
		// pure x axis both ways
		list.push_back(make_req(1, 32'sh0001_0000, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0));
		list.push_back(make_req(1, -32'sh0001_0000, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0));
		foreach (list[i])
			send_request(list[i]);
	endtask

	task automatic test_absent_target();
		send_request(make_req(0, 32'sh7FFF_FFFF, 32'sd1, 32'sd2, 32'sd3, 32'sd4, 32'sd5));
		send_request(make_req(1, 32'sd100, 32'sd200, 32'sd300, 32'sd0, 32'sd0, 32'sd0));
		send_request(make_req(0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0));
		send_request(make_req(0, 32'sh8000_0000, -32'sd1, 32'sd9, 32'sd1, 32'sd1, 32'sd1));
		send_request(make_req(1, -32'sd100, 32'sd200, -32'sd300, 32'sd0, 32'sd0, 32'sd0));
	endtask

	task automatic test_random_traffic();
		look_req_t r;
		int        sent;
		sent = 0;
		while (sent < RANDOM_REQS) begin
			r = random_req();
			send_request(r);
			if (r.present)
				sent++;
			pace((sent / 150) % 3 == 2);
		end
	endtask

	always @(posedge clk) begin
		look_angles_t exp_a;
		if (arst_n && done) begin
			if (expected_angles.size() == 0) begin
				$display("%0t: unexpected result pitch=%0d yaw=%0d", $time, pitch_angle, yaw_angle);
				mismatches++;
			end else begin
				exp_a = expected_angles.pop_front();
				if (pitch_angle !== exp_a.pitch) begin
					$display("%0t: pitch_angle expected %0d actual %0d",
						$time, exp_a.pitch, pitch_angle);
					mismatches++;
				end
				if (yaw_angle !== exp_a.yaw) begin
					$display("%0t: yaw_angle expected %0d actual %0d",
						$time, exp_a.yaw, yaw_angle);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("look_at_yaw_pitch_core_tb failed");
			$finish;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_coordinate_extremes();
		start <= 1'b0;
		repeat (3) @(posedge clk);
		test_special_cases();
		pace(1'b0);
		test_absent_target();
		pace(1'b0);
		test_random_traffic();
		start <= 1'b0;
		while (expected_angles.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
		if (mismatches == 0 && expected_angles.size() == 0)
			$display("look_at_yaw_pitch_core_tb passed");
		else
			$display("look_at_yaw_pitch_core_tb failed");
		$finish;
	end

endmodule
